// ===== hw/rtl/bemc_pkg.sv =====
// Package for the boom energy mode controller.
// Holds the item structs, the mode codes, the register indexes and the thresholds.
// It has no dependencies and is used by boom_energy_mode_controller.
package bemc_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAL_GRADE  = 2'd1;

  localparam logic       RST_SAVE_ENABLE = 1'b1;
  localparam logic [3:0] RST_DIAL_GRADE  = 4'd10;

  // Boom operating modes.
  typedef enum logic [2:0] {
    MODE_LOWER   = 3'd0,
    MODE_RAISE   = 3'd1,
    MODE_LOWEN   = 3'd2,
    MODE_NEUTRAL = 3'd3,
    MODE_PROP    = 3'd4,
    MODE_NOSAVE  = 3'd5,
    MODE_RELIEF  = 3'd6
  } mode_t;

  // Pressure thresholds in bar.
  localparam logic [9:0] P_BIG_HIGH     = 10'd150;
  localparam logic [9:0] P_BIG_LOW      = 10'd50;
  localparam logic [9:0] P_ACC_UP_SET   = 10'd195;
  localparam logic [9:0] P_ACC_UP_CLR   = 10'd190;
  localparam logic [9:0] P_ACC_BACK     = 10'd210;
  localparam logic [9:0] P_ACC_DOWN     = 10'd215;
  localparam logic [9:0] P_DT7_SET      = 10'd290;
  localparam logic [9:0] P_DT7_CLR      = 10'd250;
  localparam logic [9:0] P_THR_HIGH     = 10'd320;
  localparam logic [9:0] P_THR_MID      = 10'd315;
  localparam logic [9:0] P_THR_LOW      = 10'd305;
  localparam logic [10:0] P_PROP_MARGIN = 11'd50;
  localparam logic [3:0] DIAL_TOP       = 4'd10;
  localparam logic [3:0] DIAL_MID       = 4'd9;

  // Timer thresholds in 10 ms ticks.
  localparam logic [15:0] T_RAISE_ENTRY = 16'd50;
  localparam logic [15:0] T_PROP_ENTRY  = 16'd100;
  localparam logic [15:0] T_LOWEN_DROP  = 16'd10;
  localparam logic [15:0] T_NEUTRAL_V1  = 16'd1;
  localparam logic [15:0] T_NEUTRAL_ALL = 16'd200;
  localparam logic [15:0] T_PROP_V1     = 16'd40;
  localparam logic [15:0] T_NOSAVE_DROP = 16'd10;
  localparam logic [15:0] T_MAX         = 16'hFFFF;

  // One input item.
  typedef struct packed {
    logic       tick_10ms;
    logic       boom_up_pilot;
    logic       boom_down_pilot;
    logic       relief_request;
    logic       restart_event;
    logic [9:0] big_chamber_bar;
    logic [9:0] small_chamber_bar;
    logic [9:0] accum_bar;
    logic [9:0] pump_two_bar;
    logic       pilot_sensor_fault;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0] work_mode;
    logic       valve_one;
    logic       valve_two;
    logic       valve_seven;
    logic       valve_eight;
    logic       lower_mode_active;
  } out_item_t;

endpackage

// ===== hw/rtl/boom_energy_mode_controller.sv =====
// Boom energy mode controller: mode selection, hysteresis latches, timers, solenoids.
// Depends on bemc_pkg for item structs, mode codes and thresholds.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+----------------------------------
//   in      | in_valid / in_stall       | in_data  (bemc_pkg::in_item_t)
//   out     | out_valid / out_stall     | out_data (bemc_pkg::out_item_t)
//   cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// An item is captured in the input register, then evaluated combinationally against the
// controller state, which is updated in the same edge that loads the result register.
// One item per cycle is sustained unless the output stalls, set by the state update loop.
// Reset (synchronous, rst_n low) clears timers, latches, valves and valid flags and
// loads the register defaults. A stalled result holds; one more item waits at the input.
module boom_energy_mode_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bemc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bemc_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bemc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bemc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bemc_pkg::*;

  typedef struct packed {
    logic restart;
    logic first;
    logic back;
    logic prop;
    logic afterprop;
    logic upin;
    logic uplow;
    logic bigload;
    logic downfirst;
    logic dt7;
  } latch_t;

  typedef struct packed {
    logic v1;
    logic v2;
    logic v7;
    logic v8;
  } valve_t;

  // Saturating tick counter that clears when its condition drops.
  function automatic logic [15:0] tick_count(input logic [15:0] t, input logic cond);
    logic [15:0] res;
    if (!cond) begin
      res = '0;
    end else if (t != T_MAX) begin
      res = t + 16'd1;
    end else begin
      res = t;
    end
    return res;
  endfunction

  logic        save_en_r;
  logic [3:0]  dial_r;
  in_item_t    in_r;
  logic        in_vld_r;
  out_item_t   out_r;
  logic        out_vld_r;
  logic [15:0] prop_entry_r, raise_entry_r, lowen_tmr_r, prop_tmr_r, nosave_tmr_r;
  logic [15:0] neutral_tmr_r;
  latch_t      lat_r;
  valve_t      valve_r;
  logic        lower_flag_r;

  logic        advance;
  mode_t       mode;
  latch_t      lat_nxt;
  valve_t      valve_nxt;
  logic        lower_flag_nxt;
  logic [9:0]  thr;
  logic [10:0] big_margin;

  // Handshakes: the stage advances when the result register is free or being emptied.
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      save_en_r <= RST_SAVE_ENABLE;
      dial_r    <= RST_DIAL_GRADE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SAVE_ENABLE: save_en_r <= cfg_data[0];
        CFG_DIAL_GRADE:  dial_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= (in_valid && !in_stall) || (in_vld_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  // Mode selection, latch updates and solenoid drive for the registered item.
  always_comb begin
    lat_nxt        = lat_r;
    valve_nxt      = valve_r;
    lower_flag_nxt = lower_flag_r;
    mode           = MODE_NOSAVE;

    if (in_r.restart_event) begin
      lat_nxt.restart = 1'b1;
    end

    if (in_r.relief_request) begin
      mode = MODE_RELIEF;
    end else if (save_en_r) begin
      // Raise decision.
      if (in_r.boom_up_pilot) begin
        if (lat_nxt.restart) begin
          lat_nxt.first = 1'b1;
          if (lat_nxt.back) begin
            lat_nxt.restart = 1'b0;
            lat_nxt.back    = 1'b0;
          end
          mode = MODE_NOSAVE;
          if (in_r.big_chamber_bar > P_BIG_HIGH) lat_nxt.prop = 1'b0;
        end else if (in_r.big_chamber_bar <= P_BIG_LOW || lat_nxt.afterprop) begin
          mode = MODE_NOSAVE;
          lat_nxt.afterprop = 1'b1;
          if (in_r.big_chamber_bar > P_BIG_HIGH) begin
            lat_nxt.afterprop = 1'b0;
            lat_nxt.prop      = 1'b0;
          end
        end else if ((in_r.accum_bar > P_ACC_UP_SET || lat_nxt.upin) && !lat_nxt.uplow) begin
          lat_nxt.upin = 1'b1;
          if (in_r.accum_bar < P_ACC_UP_CLR) lat_nxt.upin = 1'b0;
          if (raise_entry_r >= T_RAISE_ENTRY || lat_nxt.bigload) begin
            mode = MODE_NOSAVE;
            lat_nxt.bigload = 1'b1;
          end else begin
            mode = MODE_RAISE;
          end
        end else begin
          mode = MODE_LOWEN;
          lat_nxt.uplow = 1'b1;
        end
      end
      // Lowering decision overrides the raise decision.
      if (in_r.boom_down_pilot) begin
        if (lat_nxt.first && in_r.accum_bar > P_ACC_BACK) begin
          lat_nxt.first = 1'b0;
          lat_nxt.back  = 1'b1;
        end
        if (in_r.accum_bar < P_ACC_DOWN || lat_nxt.downfirst) begin
          lat_nxt.downfirst = 1'b1;
          if (prop_entry_r > T_PROP_ENTRY || lat_nxt.prop) begin
            mode = MODE_PROP;
            lat_nxt.prop = 1'b1;
          end else begin
            mode = MODE_LOWER;
          end
        end else begin
          mode = MODE_NOSAVE;
        end
      end
      if (!in_r.boom_up_pilot && !in_r.boom_down_pilot) begin
        mode = MODE_NEUTRAL;
        lat_nxt.uplow = 1'b0;
      end
    end

    // Solenoid drive; bits a mode does not touch keep their value.
    unique case (mode)
      MODE_LOWER: begin
        lower_flag_nxt = 1'b1;
        valve_nxt.v1 = 1'b0;
        valve_nxt.v2 = 1'b1;
        valve_nxt.v8 = 1'b1;
      end
      MODE_RAISE: begin
        valve_nxt.v1 = 1'b0;
        valve_nxt.v2 = 1'b1;
        valve_nxt.v8 = 1'b1;
        if (in_r.pump_two_bar >= P_DT7_SET || lat_nxt.dt7) begin
          valve_nxt.v7 = 1'b1;
          lat_nxt.dt7  = 1'b1;
          if (in_r.pump_two_bar < P_DT7_CLR) lat_nxt.dt7 = 1'b0;
        end else begin
          valve_nxt.v7 = 1'b0;
        end
      end
      MODE_LOWEN: begin
        valve_nxt.v7 = 1'b1;
        valve_nxt.v1 = 1'b1;
        if (lowen_tmr_r > T_LOWEN_DROP) begin
          valve_nxt.v2 = 1'b0;
          valve_nxt.v8 = 1'b0;
        end
      end
      MODE_NEUTRAL: begin
        lower_flag_nxt    = 1'b0;
        lat_nxt.dt7       = 1'b0;
        lat_nxt.downfirst = 1'b0;
        lat_nxt.bigload   = 1'b0;
        if (neutral_tmr_r >= (valve_r.v1 ? T_NEUTRAL_V1 : T_NEUTRAL_ALL)) begin
          valve_nxt.v1 = 1'b0;
          valve_nxt.v2 = 1'b0;
          valve_nxt.v8 = 1'b0;
        end
        valve_nxt.v7 = 1'b0;
      end
      MODE_PROP: begin
        valve_nxt.v2 = 1'b0;
        valve_nxt.v8 = 1'b0;
        valve_nxt.v7 = 1'b0;
        if (prop_tmr_r >= T_PROP_V1) valve_nxt.v1 = 1'b1;
      end
      MODE_RELIEF: begin
        valve_nxt.v1 = 1'b1;
        valve_nxt.v2 = 1'b1;
        valve_nxt.v8 = 1'b1;
      end
      default: begin
        valve_nxt.v1 = !(!in_r.pilot_sensor_fault && neutral_tmr_r >= T_NEUTRAL_V1);
        if (nosave_tmr_r >= T_NOSAVE_DROP) begin
          valve_nxt.v2 = 1'b0;
          valve_nxt.v8 = 1'b0;
        end
        valve_nxt.v7 = 1'b1;
      end
    endcase
  end

  // Raise threshold from the dial, and the rod-side margin for prop entry.
  assign thr = (dial_r >= DIAL_TOP) ? P_THR_HIGH :
               ((dial_r == DIAL_MID) ? P_THR_MID : P_THR_LOW);
  assign big_margin = {1'b0, in_r.big_chamber_bar} + P_PROP_MARGIN;

  // Controller state; timers see the old values above and advance afterwards.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_entry_r  <= '0;
      raise_entry_r <= '0;
      lowen_tmr_r   <= '0;
      prop_tmr_r    <= '0;
      nosave_tmr_r  <= '0;
      neutral_tmr_r <= '0;
      lat_r         <= '0;
      valve_r       <= '0;
      lower_flag_r  <= 1'b0;
    end else if (advance) begin
      lat_r        <= lat_nxt;
      valve_r      <= valve_nxt;
      lower_flag_r <= lower_flag_nxt;
      if (in_r.tick_10ms) begin
        prop_entry_r  <= tick_count(prop_entry_r, in_r.boom_down_pilot &&
                                    ({1'b0, in_r.small_chamber_bar} >= big_margin));
        raise_entry_r <= tick_count(raise_entry_r, in_r.boom_up_pilot &&
                                    (in_r.pump_two_bar >= thr));
        prop_tmr_r    <= tick_count(prop_tmr_r, mode == MODE_PROP);
        lowen_tmr_r   <= tick_count(lowen_tmr_r, mode == MODE_LOWEN);
        neutral_tmr_r <= tick_count(neutral_tmr_r,
                                    !in_r.boom_up_pilot && !in_r.boom_down_pilot);
        nosave_tmr_r  <= tick_count(nosave_tmr_r, mode == MODE_NOSAVE);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= advance || (out_vld_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.work_mode         <= mode;
      out_r.valve_one         <= valve_nxt.v1;
      out_r.valve_two         <= valve_nxt.v2;
      out_r.valve_seven       <= valve_nxt.v7;
      out_r.valve_eight       <= valve_nxt.v8;
      out_r.lower_mode_active <= lower_flag_nxt;
    end
  end

  // The input side only stalls while it holds an item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with an empty input register");

  // Relief mode always opens DT1, DT2 and DT8.
  a_relief_valves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.work_mode == MODE_RELIEF) |->
      (out_r.valve_one && out_r.valve_two && out_r.valve_eight))
    else $error("relief result without DT1, DT2 and DT8");

  // Lower mode raises the lower flag, neutral mode drops it.
  a_lower_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.work_mode == MODE_LOWER) |-> out_r.lower_mode_active)
    else $error("lower result without lower flag");

  a_neutral_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.work_mode == MODE_NEUTRAL) |->
      (!out_r.lower_mode_active && !out_r.valve_seven))
    else $error("neutral result with lower flag or DT7 set");

  // Timers only move on an item that carries a tick.
  a_timer_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && in_r.tick_10ms) |=> ($stable(neutral_tmr_r) && $stable(prop_entry_r)))
    else $error("timer changed without a tick");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for boom_energy_mode_controller: directed mode items, then
// random pilot/pressure sequences under several register settings with random stalls.
// Depends on bemc_pkg and the controller RTL; it carries its own cycle-level predictor.
`timescale 1ns / 1ps

module tb_top;
  import bemc_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_WAIT   = 8;

  // Kinds of random sequence that the stimulus strings together.
  typedef enum {SEG_NEUTRAL, SEG_RAISE, SEG_LOWER, SEG_BOTH, SEG_RELIEF, SEG_NOISE} seg_kind_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SAVE_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  boom_energy_mode_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the register settings and of the controller state.
  bit          cfg_save_on    = 1'b1;
  logic [3:0]  cfg_grade      = 4'd10;
  logic [15:0] tmr_prop_entry = '0;
  logic [15:0] tmr_raise_entry = '0;
  logic [15:0] tmr_low_energy = '0;
  logic [15:0] tmr_prop_mode  = '0;
  logic [15:0] tmr_no_save    = '0;
  logic [15:0] tmr_neutral    = '0;
  bit lat_restart = 1'b0, lat_first_raise = 1'b0, lat_back = 1'b0, lat_prop = 1'b0;
  bit lat_after_prop = 1'b0, lat_up_in = 1'b0, lat_up_low = 1'b0, lat_big_load = 1'b0;
  bit lat_down_first = 1'b0, lat_dt7 = 1'b0;
  bit vlv_one = 1'b0, vlv_two = 1'b0, vlv_seven = 1'b0, vlv_eight = 1'b0;
  bit lowering_flag = 1'b0;

  // Run control and bookkeeping.
  bit        quiet_tail     = 1'b0;
  bit        sender_gaps_on = 1'b1;
  bit        hold_request   = 1'b0;
  int        items_sent     = 0;
  int        results_seen   = 0;
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  out_item_t pending_results[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Saturating 10 ms timer step: clears whenever its condition is false.
  function automatic logic [15:0] next_timer(logic [15:0] t, bit run);
    if (!run) return '0;
    return (t == 16'hFFFF) ? t : t + 16'd1;
  endfunction

  // One control cycle: pick the mode, drive the valves, then advance the timers.
  function automatic out_item_t predict_boom_cycle(in_item_t it);
    int        big_p, rod_p, acc_p, pump_p, thr;
    bit        up, down;
    mode_t     m;
    out_item_t r;
    big_p  = it.big_chamber_bar;
    rod_p  = it.small_chamber_bar;
    acc_p  = it.accum_bar;
    pump_p = it.pump_two_bar;
    up     = it.boom_up_pilot;
    down   = it.boom_down_pilot;
    if (it.restart_event) lat_restart = 1'b1;

    // Relief wins outright; with saving off everything runs unsaved.
    m = MODE_NOSAVE;
    if (it.relief_request) begin
      m = MODE_RELIEF;
    end else if (cfg_save_on) begin
      if (up) begin
        if (lat_restart) begin
          // First raise after a restart runs without saving.
          lat_first_raise = 1'b1;
          if (lat_back) begin
            lat_restart = 1'b0;
            lat_back    = 1'b0;
          end
          if (big_p > 150) lat_prop = 1'b0;
        end else if (big_p <= 50 || lat_after_prop) begin
          lat_after_prop = 1'b1;
          if (big_p > 150) begin
            lat_after_prop = 1'b0;
            lat_prop       = 1'b0;
          end
        end else if ((acc_p > 195 || lat_up_in) && !lat_up_low) begin
          lat_up_in = 1'b1;
          if (acc_p < 190) lat_up_in = 1'b0;
          if (tmr_raise_entry >= 16'd50 || lat_big_load) lat_big_load = 1'b1;
          else m = MODE_RAISE;
        end else begin
          m          = MODE_LOWEN;
          lat_up_low = 1'b1;
        end
      end
      // Lowering overrides whatever the raise decision picked.
      if (down) begin
        if (lat_first_raise && acc_p > 210) begin
          lat_first_raise = 1'b0;
          lat_back        = 1'b1;
        end
        if (acc_p < 215 || lat_down_first) begin
          lat_down_first = 1'b1;
          if (tmr_prop_entry > 16'd100 || lat_prop) begin
            m        = MODE_PROP;
            lat_prop = 1'b1;
          end else begin
            m = MODE_LOWER;
          end
        end else begin
          m = MODE_NOSAVE;
        end
      end
      if (!up && !down) begin
        m          = MODE_NEUTRAL;
        lat_up_low = 1'b0;
      end
    end

    // Solenoids; bits that a mode leaves alone keep their value.
    case (m)
      MODE_LOWER: begin
        lowering_flag = 1'b1;
        vlv_one       = 1'b0;
        vlv_two       = 1'b1;
        vlv_eight     = 1'b1;
      end
      MODE_RAISE: begin
        vlv_one   = 1'b0;
        vlv_two   = 1'b1;
        vlv_eight = 1'b1;
        if (pump_p >= 290 || lat_dt7) begin
          vlv_seven = 1'b1;
          lat_dt7   = 1'b1;
          if (pump_p < 250) lat_dt7 = 1'b0;
        end else begin
          vlv_seven = 1'b0;
        end
      end
      MODE_LOWEN: begin
        vlv_seven = 1'b1;
        vlv_one   = 1'b1;
        if (tmr_low_energy > 16'd10) begin
          vlv_two   = 1'b0;
          vlv_eight = 1'b0;
        end
      end
      MODE_NEUTRAL: begin
        lowering_flag  = 1'b0;
        lat_dt7        = 1'b0;
        lat_down_first = 1'b0;
        lat_big_load   = 1'b0;
        if (tmr_neutral >= (vlv_one ? 16'd1 : 16'd200)) begin
          vlv_one   = 1'b0;
          vlv_two   = 1'b0;
          vlv_eight = 1'b0;
        end
        vlv_seven = 1'b0;
      end
      MODE_PROP: begin
        vlv_two   = 1'b0;
        vlv_eight = 1'b0;
        vlv_seven = 1'b0;
        if (tmr_prop_mode >= 16'd40) vlv_one = 1'b1;
      end
      MODE_RELIEF: begin
        vlv_one   = 1'b1;
        vlv_two   = 1'b1;
        vlv_eight = 1'b1;
      end
      default: begin
        vlv_one = it.pilot_sensor_fault || tmr_neutral < 16'd1;
        if (tmr_no_save >= 16'd10) begin
          vlv_two   = 1'b0;
          vlv_eight = 1'b0;
        end
        vlv_seven = 1'b1;
      end
    endcase

    // Timers move after the mode is chosen, and only on a tick.
    thr = (cfg_grade >= 4'd10) ? 320 : ((cfg_grade == 4'd9) ? 315 : 305);
    if (it.tick_10ms) begin
      tmr_prop_entry  = next_timer(tmr_prop_entry, down && rod_p >= big_p + 50);
      tmr_raise_entry = next_timer(tmr_raise_entry, up && pump_p >= thr);
      tmr_prop_mode   = next_timer(tmr_prop_mode, m == MODE_PROP);
      tmr_low_energy  = next_timer(tmr_low_energy, m == MODE_LOWEN);
      tmr_neutral     = next_timer(tmr_neutral, !up && !down);
      tmr_no_save     = next_timer(tmr_no_save, m == MODE_NOSAVE);
    end

    r.work_mode         = m;
    r.valve_one         = vlv_one;
    r.valve_two         = vlv_two;
    r.valve_seven       = vlv_seven;
    r.valve_eight       = vlv_eight;
    r.lower_mode_active = lowering_flag;
    return r;
  endfunction

  task automatic check_field(string field, logic [2:0] want_v, logic [2:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Predict on every accepted item and check every accepted result in order.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) pending_results.push_back(predict_boom_cycle(in_data));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result item %h arrived with nothing expected", $time, out_data);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("work_mode", want.work_mode, out_data.work_mode);
          check_field("valve_one", 3'(want.valve_one), 3'(out_data.valve_one));
          check_field("valve_two", 3'(want.valve_two), 3'(out_data.valve_two));
          check_field("valve_seven", 3'(want.valve_seven), 3'(out_data.valve_seven));
          check_field("valve_eight", 3'(want.valve_eight), 3'(out_data.valve_eight));
          check_field("lower_mode_active", 3'(want.lower_mode_active),
                      3'(out_data.lower_mode_active));
        end
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t: run did not finish in %0d cycles", $time, RUN_LIMIT);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Offer one item until it is taken, then maybe leave a gap.
  task automatic send_item(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (sender_gaps_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stop offering items and wait until every result has come back.
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  // Write both registers back to back; the predictor follows each write.
  task automatic write_settings(bit save_on, logic [3:0] grade);
    logic [CFG_DATA_W-2:0] pad;
    pad = (CFG_DATA_W-1)'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SAVE_ENABLE;
    cfg_data  <= {pad, save_on};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_save_on = save_on;
    cfg_index <= CFG_DIAL_GRADE;
    cfg_data  <= grade;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_grade = grade;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t pack_item(bit tick, bit up, bit down, bit relief, bit restart,
                                         int big_p, int rod_p, int acc_p, int pump_p,
                                         bit fault);
    in_item_t it;
    it.tick_10ms          = tick;
    it.boom_up_pilot      = up;
    it.boom_down_pilot    = down;
    it.relief_request     = relief;
    it.restart_event      = restart;
    it.big_chamber_bar    = big_p[9:0];
    it.small_chamber_bar  = rod_p[9:0];
    it.accum_bar          = acc_p[9:0];
    it.pump_two_bar       = pump_p[9:0];
    it.pilot_sensor_fault = fault;
    return it;
  endfunction

  // A pressure near a base value, kept inside the 10-bit range.
  function automatic logic [9:0] near_bar(int base, int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  // Random operating sequences: held pilots with slowly wandering pressures, mostly
  // ticking, so the timers and latches get deep; some pure noise in between.
  task automatic run_random_phase(int n_items);
    int          sent, len, acc_base, big_base, pump_base;
    seg_kind_t   kind;
    logic [63:0] noise;
    in_item_t    it;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1:    kind = SEG_NEUTRAL;
        2, 3:    kind = SEG_RAISE;
        4, 5:    kind = SEG_LOWER;
        6:       kind = SEG_BOTH;
        7:       kind = SEG_RELIEF;
        default: kind = SEG_NOISE;
      endcase
      acc_base  = $urandom_range(170, 240);
      big_base  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(40, 400);
      pump_base = $urandom_range(230, 340);
      case (kind)
        SEG_NEUTRAL:
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 210) : $urandom_range(1, 12);
        SEG_RAISE:
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 15);
        SEG_LOWER:
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 150) : $urandom_range(1, 15);
        default:
          len = $urandom_range(1, 6);
      endcase
      // The last sequence of a phase is cut to the items that remain.
      if (len > n_items - sent) len = n_items - sent;
      repeat (len) begin
        noise = {$urandom, $urandom};
        it    = noise[$bits(in_item_t)-1:0];
        if (kind != SEG_NOISE) begin
          it.tick_10ms          = ($urandom_range(0, 7) != 0);
          it.boom_up_pilot      = (kind == SEG_RAISE || kind == SEG_BOTH);
          it.boom_down_pilot    = (kind == SEG_LOWER || kind == SEG_BOTH);
          it.relief_request     = (kind == SEG_RELIEF);
          it.restart_event      = ($urandom_range(0, 79) == 0);
          it.pilot_sensor_fault = ($urandom_range(0, 3) == 0);
          it.big_chamber_bar    = near_bar(big_base, 8);
          it.accum_bar          = near_bar(acc_base, 6);
          it.pump_two_bar       = near_bar(pump_base, 12);
          // Keep rod minus head pressure around the prop entry margin.
          if (kind == SEG_LOWER || kind == SEG_BOTH)
            it.small_chamber_bar = near_bar(int'(it.big_chamber_bar) + 50, 10);
        end
        send_item(it);
        sent++;
      end
    end
  endtask

  // Field extremes and a walk through every mode but prop and the latch paths at reset settings.
  task automatic test_directed_modes();
    send_item(pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(pack_item(1, 1, 1, 1, 1, 1023, 1023, 1023, 1023, 1));
    // Restart latch is set: the first raise goes unsaved, then a lower arms the release.
    send_item(pack_item(1, 1, 0, 0, 0, 200, 0, 200, 300, 1));
    send_item(pack_item(1, 0, 1, 0, 0, 100, 200, 220, 0, 0));
    send_item(pack_item(1, 1, 0, 0, 0, 100, 0, 200, 300, 0));
    // Saving raise with the pump merge valve hysteresis.
    send_item(pack_item(1, 1, 0, 0, 0, 100, 0, 200, 300, 0));
    send_item(pack_item(1, 1, 0, 0, 0, 100, 0, 192, 240, 0));
    send_item(pack_item(1, 1, 0, 0, 0, 100, 0, 185, 260, 0));
    // Low accumulator: low-energy raise, then lowering and both pilots together.
    send_item(pack_item(1, 1, 0, 0, 0, 100, 0, 185, 260, 0));
    send_item(pack_item(1, 0, 1, 0, 0, 100, 200, 100, 0, 0));
    send_item(pack_item(1, 1, 1, 0, 0, 100, 160, 200, 300, 0));
    send_item(pack_item(1, 0, 0, 0, 0, 1023, 0, 1023, 1023, 0));
    // Light head pressure blocks saving until a heavy load is seen.
    send_item(pack_item(1, 1, 0, 0, 0, 30, 0, 200, 0, 0));
    send_item(pack_item(1, 1, 0, 0, 0, 500, 0, 200, 0, 0));
    send_item(pack_item(1, 1, 0, 0, 0, 500, 0, 200, 0, 0));
    send_item(pack_item(0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    send_item(pack_item(1, 0, 1, 0, 0, 0, 1023, 300, 0, 1));
    send_item(pack_item(0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_input_backpressure();
    hold_request   = 1'b1;
    sender_gaps_on = 1'b0;
    run_random_phase(30);
    sender_gaps_on = 1'b1;
  endtask

  // Raise threshold across dial grades, including both ends of the range.
  task automatic test_dial_grades();
    logic [3:0] grades[4] = '{4'd15, 4'd9, 4'd8, 4'd0};
    foreach (grades[i]) begin
      wait_drained();
      write_settings(1'b1, grades[i]);
      run_random_phase(160);
    end
  endtask

  task automatic test_save_disable();
    wait_drained();
    write_settings(1'b0, 4'd12);
    run_random_phase(70);
  endtask

  // Last stretch back at default settings with neither side idling.
  task automatic test_quiet_tail();
    wait_drained();
    write_settings(1'b1, 4'd10);
    quiet_tail = 1'b1;
    run_random_phase(200);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_modes();
    test_input_backpressure();
    test_dial_grades();
    test_save_disable();
    test_quiet_tail();
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_results.size() != 0)
      $display("%0t: %0d expected result items never arrived", $time, pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
